/* hw/rtl/rsi_pkg.sv */
// ---------------------------------------------------------------------------
// rsi_pkg - shared types and constants of the ray/sphere intersect pipeline
// Fixed-point widths and the sideband words carried through the root and
// quotient pipelines.
// ---------------------------------------------------------------------------
`default_nettype none
package rsi_pkg;

  localparam int POS_FRAC_BITS = 20;
  localparam int VEC_FRAC_BITS = 16;

  localparam int VEC_W  = 18;               // unit vector component
  localparam int POS_W  = 24;               // position / centre
  localparam int RAD_W  = 23;               // radius
  localparam int DIST_W = 26;               // output distances
  localparam int D_W    = POS_W + 1;        // point minus centre
  localparam int PRD_W  = VEC_W + D_W;      // e * d
  localparam int DOT_W  = PRD_W + 2;        // sum of three products
  localparam int B_W    = DOT_W - VEC_FRAC_BITS;
  localparam int SQ_W   = 2 * D_W;          // d * d
  localparam int DD_W   = 2 * D_W + 1;      // |d|^2, unsigned
  localparam int R2_W   = 2 * RAD_W;        // r^2, unsigned
  localparam int C_W    = DD_W + 1;         // c, signed
  localparam int BB_W   = 2 * B_W;          // b^2, signed product
  localparam int RADQ_W = BB_W;             // sqrt radicand
  localparam int ROOT_W = RADQ_W / 2;       // sqrt result
  localparam int EXIT_W = B_W + 1;          // -b + s before saturation
  localparam int DVD_W  = DD_W - 1;         // positive c fits here
  localparam int DCMP_W = EXIT_W + DIST_W;  // divisor shifted to the top

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } rsi_reg_t;

  typedef struct packed {
    logic                  hit;
    logic signed [B_W-1:0] b;
    logic signed [C_W-1:0] c;
  } rsi_sq_side_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] exit_dist;
  } rsi_dv_side_t;

endpackage
`default_nettype wire

/* hw/rtl/rsi_sqrt.sv */
// ---------------------------------------------------------------------------
// rsi_sqrt - pipelined integer square root
// One root bit per stage, digit-by-digit, floor result; sideband rides along.
// ---------------------------------------------------------------------------
`default_nettype none
module rsi_sqrt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire  [rsi_pkg::RADQ_W-1:0]   in_rad,
  input  rsi_pkg::rsi_sq_side_t        in_side,
  output logic                         out_valid,
  output logic [rsi_pkg::ROOT_W-1:0]   out_root,
  output rsi_pkg::rsi_sq_side_t        out_side
);
  import rsi_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic                 v_r    [0:ROOT_W];
  logic [RADQ_W-1:0]    rad_r  [0:ROOT_W];
  logic [REM_W-1:0]     rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]    root_r [0:ROOT_W];
  rsi_sq_side_t         side_r [0:ROOT_W];

  always_comb begin
    v_r[0]    = in_valid;
    rad_r[0]  = in_rad;
    rem_r[0]  = '0;
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic              v_q;
    logic [RADQ_W-1:0] rad_q;
    logic [REM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    rsi_sq_side_t      side_q;

    always_comb begin
      cur   = {rem_r[i][REM_W-3:0], rad_r[i][RADQ_W-1-2*i -: 2]};
      trial = {1'b0, root_r[i], 2'b01};
      if (cur >= trial) begin
        rem_nxt  = cur - trial;
        root_nxt = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_r[i][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q  <= rad_r[i];
        rem_q  <= rem_nxt;
        root_q <= root_nxt;
        side_q <= side_r[i];
      end
    end

    always_comb begin
      v_r[i+1]    = v_q;
      rad_r[i+1]  = rad_q;
      rem_r[i+1]  = rem_q;
      root_r[i+1] = root_q;
      side_r[i+1] = side_q;
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule
`default_nettype wire

/* hw/rtl/rsi_div.sv */
// ---------------------------------------------------------------------------
// rsi_div - pipelined saturating restoring divider
// Overflow check first, then one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module rsi_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire  [rsi_pkg::EXIT_W-1:0]   in_divisor,
  input  wire  [rsi_pkg::DVD_W-1:0]    in_dividend,
  input  rsi_pkg::rsi_dv_side_t        in_side,
  output logic                         out_valid,
  output logic [rsi_pkg::DIST_W-1:0]   out_quot,
  output rsi_pkg::rsi_dv_side_t        out_side
);
  import rsi_pkg::*;

  logic                v_r    [0:DIST_W];
  logic [DVD_W-1:0]    rem_r  [0:DIST_W];
  logic [EXIT_W-1:0]   dvs_r  [0:DIST_W];
  logic [DIST_W-1:0]   quo_r  [0:DIST_W];
  logic                ovf_r  [0:DIST_W];
  rsi_dv_side_t        side_r [0:DIST_W];

  // overflow stage: quotient would not fit when dividend >= divisor << DIST_W
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_dividend;
      dvs_r[0]  <= in_divisor;
      quo_r[0]  <= '0;
      ovf_r[0]  <= {{(DCMP_W-DVD_W){1'b0}}, in_dividend} >= {in_divisor, {DIST_W{1'b0}}};
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < DIST_W; i++) begin : g_stage
    logic [DCMP_W-1:0] shv;
    logic [DCMP_W-1:0] remx;
    logic              take;

    always_comb begin
      shv  = {{DIST_W{1'b0}}, dvs_r[i]} << (DIST_W - 1 - i);
      remx = {{(DCMP_W-DVD_W){1'b0}}, rem_r[i]};
      take = remx >= shv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= take ? DVD_W'(remx - shv) : rem_r[i];
        dvs_r[i+1]  <= dvs_r[i];
        quo_r[i+1]  <= quo_r[i] | (DIST_W'(take) << (DIST_W - 1 - i));
        ovf_r[i+1]  <= ovf_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = v_r[DIST_W];
  assign out_quot  = ovf_r[DIST_W] ? DIST_MAX : quo_r[DIST_W];
  assign out_side  = side_r[DIST_W];

endmodule
`default_nettype wire

/* hw/rtl/ray_sphere_intersect.sv */
// ---------------------------------------------------------------------------
// ray_sphere_intersect - forward ray versus configured sphere, fixed point
// Stages: 6 front stages, 29 square-root stages, 1 exit stage and 27 divider
//   stages from input accept to result valid.
// Throughput: one word per cycle; the whole pipeline holds while a result
//   waits on out_tready.
// Reset: synchronous active-low rst_n clears all valid bits and the sphere
//   registers (centre and radius read as zero).
// ---------------------------------------------------------------------------
`default_nettype none
module ray_sphere_intersect (
  input  wire          clk,
  input  wire          rst_n,
  // configuration write port
  input  wire          cfg_wen,
  input  wire  [1:0]   cfg_index,
  input  wire  [23:0]  cfg_wdata,
  // input stream
  input  wire          in_tvalid,
  output logic         in_tready,
  // earth_x, earth_y, earth_z, point_x, point_y, point_z, zero pad
  input  wire  [127:0] in_tdata,
  // result stream
  output logic         out_tvalid,
  input  wire          out_tready,
  // entry_dist, exit_dist, zero pad
  output logic [55:0]  out_tdata,
  // hit
  output logic         out_tuser
);
  import rsi_pkg::*;

  // sphere registers
  logic signed [POS_W-1:0] cx_r, cy_r, cz_r;
  logic        [RAD_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= '0;
    end else if (cfg_wen) begin
      case (rsi_reg_t'(cfg_index))
        REG_CENTER_X: cx_r  <= cfg_wdata;
        REG_CENTER_Y: cy_r  <= cfg_wdata;
        REG_CENTER_Z: cz_r  <= cfg_wdata;
        REG_RADIUS:   rad_r <= cfg_wdata[RAD_W-1:0];
        default:      ;
      endcase
    end
  end

  // one enable for the whole pipeline: advance unless the result word is stuck
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // unpack the input word
  logic signed [VEC_W-1:0] ex, ey, ez;
  logic signed [POS_W-1:0] px, py, pz;
  assign ex = in_tdata[17:0];
  assign ey = in_tdata[35:18];
  assign ez = in_tdata[53:36];
  assign px = in_tdata[77:54];
  assign py = in_tdata[101:78];
  assign pz = in_tdata[125:102];

  // stage 1: d = p - C
  logic                    v1_r;
  logic signed [VEC_W-1:0] ex1_r, ey1_r, ez1_r;
  logic signed [D_W-1:0]   dx1_r, dy1_r, dz1_r;
  logic        [RAD_W-1:0] r1_r;

  // stage 2: products
  logic                    v2_r;
  logic signed [PRD_W-1:0] pxd2_r, pyd2_r, pzd2_r;
  logic signed [SQ_W-1:0]  sx2_r, sy2_r, sz2_r;
  logic        [R2_W-1:0]  r2_2_r;

  // stage 3: sums
  logic                    v3_r;
  logic signed [DOT_W-1:0] dot3_r;
  logic        [DD_W-1:0]  dd3_r;
  logic        [R2_W-1:0]  r2_3_r;

  // stage 4: b (floor shift) and c
  logic                    v4_r;
  logic                    neg4_r;
  logic signed [B_W-1:0]   b4_r;
  logic signed [C_W-1:0]   c4_r;

  // stage 5: b^2
  logic                    v5_r;
  logic                    neg5_r;
  logic signed [B_W-1:0]   b5_r;
  logic signed [C_W-1:0]   c5_r;
  logic signed [BB_W-1:0]  bb5_r;

  // stage 6: q = b^2 - c, hit decision, radicand
  logic                    v6_r;
  logic [RADQ_W-1:0]       rad6_r;
  rsi_sq_side_t            side6_r;

  logic signed [BB_W:0]    q_nxt;
  logic                    hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_comb begin
    q_nxt   = {bb5_r[BB_W-1], bb5_r} - (BB_W+1)'(c5_r);
    hit_nxt = neg5_r && !q_nxt[BB_W] && (q_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex1_r  <= ex;
      ey1_r  <= ey;
      ez1_r  <= ez;
      dx1_r  <= D_W'(px) - D_W'(cx_r);
      dy1_r  <= D_W'(py) - D_W'(cy_r);
      dz1_r  <= D_W'(pz) - D_W'(cz_r);
      r1_r   <= rad_r;

      pxd2_r <= ex1_r * dx1_r;
      pyd2_r <= ey1_r * dy1_r;
      pzd2_r <= ez1_r * dz1_r;
      sx2_r  <= dx1_r * dx1_r;
      sy2_r  <= dy1_r * dy1_r;
      sz2_r  <= dz1_r * dz1_r;
      r2_2_r <= r1_r * r1_r;

      dot3_r <= DOT_W'(pxd2_r) + DOT_W'(pyd2_r) + DOT_W'(pzd2_r);
      dd3_r  <= DD_W'(sx2_r[SQ_W-2:0]) + DD_W'(sy2_r[SQ_W-2:0]) + DD_W'(sz2_r[SQ_W-2:0]);
      r2_3_r <= r2_2_r;

      neg4_r <= dot3_r[DOT_W-1];
      b4_r   <= dot3_r[DOT_W-1:VEC_FRAC_BITS];
      c4_r   <= $signed({1'b0, dd3_r}) - $signed({{(C_W-R2_W){1'b0}}, r2_3_r});

      neg5_r <= neg4_r;
      b5_r   <= b4_r;
      c5_r   <= c4_r;
      bb5_r  <= b4_r * b4_r;

      rad6_r      <= hit_nxt ? q_nxt[RADQ_W-1:0] : '0;
      side6_r.hit <= hit_nxt;
      side6_r.b   <= b5_r;
      side6_r.c   <= c5_r;
    end
  end

  // square root
  logic                 sq_v;
  logic [ROOT_W-1:0]    sq_root;
  rsi_sq_side_t         sq_side;

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_rad    (rad6_r),
    .in_side   (side6_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 7: exit = -b + s, saturate, pick the dividend
  logic                v7_r;
  logic [EXIT_W-1:0]   exit7_r;
  logic [DVD_W-1:0]    dvd7_r;
  rsi_dv_side_t        side7_r;
  logic [EXIT_W-1:0]   exit_nxt;

  assign exit_nxt = EXIT_W'(-{sq_side.b[B_W-1], sq_side.b}) + EXIT_W'(sq_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exit7_r <= exit_nxt;
      // entry stays zero for a point on or inside the sphere
      dvd7_r  <= (sq_side.hit && !sq_side.c[C_W-1] && (sq_side.c != '0))
                 ? sq_side.c[DVD_W-1:0] : '0;
      side7_r.hit       <= sq_side.hit;
      side7_r.exit_dist <= (exit_nxt > EXIT_W'(DIST_MAX)) ? DIST_MAX
                                                         : exit_nxt[DIST_W-1:0];
    end
  end

  // entry = c / exit
  logic              dv_v;
  logic [DIST_W-1:0] dv_quot;
  rsi_dv_side_t      dv_side;

  rsi_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v7_r),
    .in_divisor  (exit7_r),
    .in_dividend (dvd7_r),
    .in_side     (side7_r),
    .out_valid   (dv_v),
    .out_quot    (dv_quot),
    .out_side    (dv_side)
  );

  // the last divider stage is the output register; zero the distances on a miss
  assign out_tvalid = dv_v;
  assign out_tuser  = dv_side.hit;
  assign out_tdata  = dv_side.hit ? {4'b0, dv_side.exit_dist, dv_quot} : '0;

endmodule
`default_nettype wire

/* hw/rtl/rsi_checker.sv */
// ---------------------------------------------------------------------------
// rsi_checker - port-level checks for ray_sphere_intersect
// Watches the stream ports only and is bound onto the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module rsi_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [55:0]  out_tdata,
  input wire         out_tuser
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // advance the input side exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 56'd0)
    else $error("miss carries nonzero distances");

  a_hit_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[51:26] != 26'd0 &&
                                out_tdata[25:0] <= out_tdata[51:26])
    else $error("hit with bad exit or entry distance");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* test/tb_ray_sphere_intersect.sv */
// ---------------------------------------------------------------------------
// tb_ray_sphere_intersect - stream test of the ray/sphere intersect block
// Drives line-of-sight / point words with bursty gaps against a stalling
// receiver, predicts hit and distances in fixed point, and checks each word.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_ray_sphere_intersect;
  import rsi_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LATENCY     = 63;

  logic         clk;
  logic         rst_n;
  logic         cfg_wen;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [55:0]  out_tdata;
  logic         out_tuser;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] entry;
    logic [DIST_W-1:0] exit_d;
  } crossing_t;

  // sphere registers as the predictor sees them
  logic signed [POS_W-1:0] sph_cx, sph_cy, sph_cz;
  logic        [RAD_W-1:0] sph_r;

  crossing_t   crossing_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          stall_mode;

  ray_sphere_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Integer square root, floor.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic crossing_t predict_crossing(
      logic signed [VEC_W-1:0] ex, ey, ez, logic signed [POS_W-1:0] px, py, pz);
    crossing_t res;
    longint dx, dy, dz, dot, b, c, q, ext;
    longint unsigned s, ent;
    res = '0;
    dx = longint'(px) - longint'(sph_cx);
    dy = longint'(py) - longint'(sph_cy);
    dz = longint'(pz) - longint'(sph_cz);
    dot = longint'(ex) * dx + longint'(ey) * dy + longint'(ez) * dz;
    if (dot >= 0) return res;
    // floor shift of a negative dot product
    b = -((-dot + (64'sd1 << VEC_FRAC_BITS) - 1) >>> VEC_FRAC_BITS);
    c = dx * dx + dy * dy + dz * dz - longint'({1'b0, sph_r}) * longint'({1'b0, sph_r});
    q = b * b - c;
    if (q <= 0) return res;
    s = root_floor(longint'(q));
    ext = -b + longint'(s);
    res.hit = 1'b1;
    res.exit_d = (ext > longint'(DIST_MAX)) ? DIST_MAX : ext[DIST_W-1:0];
    if (c > 0) begin
      ent = longint'(c) / longint'(ext);
      res.entry = (ent > longint'(DIST_MAX)) ? DIST_MAX : ent[DIST_W-1:0];
    end
    return res;
  endfunction

  // Write one sphere register; only call while the pipeline is empty.
  task automatic write_reg(rsi_reg_t idx, logic [23:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_CENTER_X: sph_cx = val;
      REG_CENTER_Y: sph_cy = val;
      REG_CENTER_Z: sph_cz = val;
      REG_RADIUS:   sph_r  = val[RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(logic [23:0] cx, cy, cz, r);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
  endtask

  // Send one word; call at a falling edge. Hold valid until accepted and
  // leave it high so the next word can follow; the caller drops it.
  task automatic send_ray(logic [VEC_W-1:0] ex, ey, ez, logic [POS_W-1:0] px, py, pz);
    in_tdata  <= {2'd0, pz, py, px, ez, ey, ex};
    in_tvalid <= 1'b1;
    crossing_q.push_back(predict_crossing(ex, ey, ez, px, py, pz));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait until every expected word is back, then drain the pipeline.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (crossing_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [VEC_W-1:0] rand_vec();
    case ($urandom_range(0, 5))
      0: return VEC_W'(65536);
      1: return VEC_W'(-65536);
      2: return VEC_W'($urandom);
      default: return VEC_W'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  // Positions mostly near the sphere so hits are common.
  function automatic logic [POS_W-1:0] rand_pos(logic [POS_W-1:0] near);
    case ($urandom_range(0, 4))
      0: return POS_W'($urandom);
      default: return near + POS_W'($urandom_range(0, 8388608) - 4194304);
    endcase
  endfunction

  task automatic random_burst(int count);
    int sent, gap;
    sent = 0;
    while (sent < count) begin
      for (int k = $urandom_range(1, 30); k > 0 && sent < count; k--) begin
        send_ray(rand_vec(), rand_vec(), rand_vec(),
                 rand_pos(sph_cx), rand_pos(sph_cy), rand_pos(sph_cz));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic test_directed;
    logic [VEC_W-1:0] one_p, one_n;
    one_p = VEC_W'(65536);
    one_n = VEC_W'(-65536);
    set_sphere(24'd0, 24'd0, 24'd0, 24'd1 << 20);
    // looking at the sphere from outside: hit with entry and exit
    send_ray(one_n, 0, 0, 24'd3 << 20, 0, 0);
    // looking away: miss
    send_ray(one_p, 0, 0, 24'd3 << 20, 0, 0);
    // passing beside it: miss
    send_ray(one_n, 0, 0, 24'd3 << 20, 24'd2 << 20, 0);
    // inside the sphere: entry zero
    send_ray(0, one_n, 0, 0, 24'd1 << 18, 0);
    // tangent ray
    send_ray(0, 0, one_n, 24'd1 << 20, 0, 24'd2 << 20);
    // field extremes
    send_ray(VEC_W'(131071), VEC_W'(131072), 0, 24'h7fffff, 24'h800000, 24'h7fffff);
    send_ray(one_n, one_n, one_n, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_ray(one_p, one_p, one_p, 24'h800000, 24'h800000, 24'h800000);
    send_ray(VEC_W'(-131072), VEC_W'(-131072), VEC_W'(-131072),
             24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_ray(0, 0, 0, 0, 0, 0);
    drain();
    // largest sphere at the far corner: saturating distances
    set_sphere(24'h800000, 24'h800000, 24'h800000, 24'h7fffff);
    send_ray(one_p, one_p, one_p, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_ray(one_n, one_n, one_n, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_ray(VEC_W'(-131072), VEC_W'(-131072), VEC_W'(-131072),
             24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_ray(one_n, 0, 0, 24'h800000, 24'h800000, 24'h800000);
    drain();
  endtask

  task automatic test_random_spheres;
    for (int ph = 0; ph < 6; ph++) begin
      set_sphere(24'($urandom), 24'($urandom), 24'($urandom),
                 (ph == 0) ? 24'd0 : 24'($urandom_range(0, 24'h7fffff)));
      stall_mode = ph % 3;
      random_burst(290);
      drain();
    end
  endtask

  // Receiver stall patterns: none, random, long periodic stalls.
  always @(negedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ((cycles % 23) < 15);
    endcase
  end

  always @(posedge clk) begin
    crossing_t want, got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit    = out_tuser;
      got.entry  = out_tdata[DIST_W-1:0];
      got.exit_d = out_tdata[2*DIST_W-1:DIST_W];
      if (crossing_q.size() == 0) begin
        $display("%0t: unexpected word hit=%0d entry=%0d exit=%0d",
                 $time, got.hit, got.entry, got.exit_d);
        errors++;
      end else begin
        want = crossing_q.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.entry !== want.entry) begin
          $display("%0t: entry_dist expected %0d actual %0d", $time, want.entry, got.entry);
          errors++;
        end
        if (got.exit_d !== want.exit_d) begin
          $display("%0t: exit_dist expected %0d actual %0d", $time, want.exit_d, got.exit_d);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stall_mode = 0;
    rst_n = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    sph_cx = '0;
    sph_cy = '0;
    sph_cz = '0;
    sph_r  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_spheres();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_div.sv
hw/rtl/ray_sphere_intersect.sv
hw/rtl/rsi_checker.sv
test/tb_ray_sphere_intersect.sv
